>>> hdl/lpq_pkg.sv
// Shared types and constants for the lidar point qualifier.
`timescale 1ns / 1ps

package lpq_pkg;

    // Register map, one 32-bit word per register.
    typedef enum logic [1:0] {
        REG_DECIMATION = 2'd0,
        REG_MIN_RANGE  = 2'd1,
        REG_MAX_RANGE  = 2'd2,
        REG_TIME_MODE  = 2'd3
    } t_reg_idx;

    localparam int COORD_W  = 24;
    localparam int RANGE_W  = 23;
    localparam int TIME_W   = 63;
    localparam int OFFSET_W = 32;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int LIM_W    = 2 * RANGE_W;

    localparam logic [7:0]         DECIMATION_RST = 8'd1;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST  = '0;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = '1;

    // Confidence field lives in tag bits [5:4].
    localparam logic [7:0] CONF_MASK  = 8'h30;
    localparam logic [7:0] CONF_MID   = 8'h10;
    localparam logic [7:0] CONF_HIGH  = 8'h00;
    localparam logic [7:0] LINE_LIMIT = 8'd4;

    // Decimation state handed to the point pipeline at acceptance.
    typedef struct packed {
        logic              keep;
        logic [TIME_W-1:0] base_ns;
    } t_decim_info;

endpackage

>>> hdl/lidar_point_qualifier.sv
// Top level of the lidar point qualifier: decimation, line and confidence checks, range gate, time offset.
`timescale 1ns / 1ps

// Usage
// - Input channel (i_valid / o_ready): one lidar point per transaction,
//   i_frame_start marks the first point of a frame.
// - Output channel (o_valid / i_ready): zero or one result per point, carrying
//   the coordinates, intensity and the time offset in ns (clamped at 0,
//   saturated at 2^32-1).
// - APB port: decimation at 0x0, min range at 0x4, max range at 0x8,
//   time mode at 0xC. Write only while no points are in flight.
// - Throughput: one point per cycle unless the receiver stalls. A result
//   shows on o_valid after its point passes the input register, the squares
//   register and the range compare into the output register.
// - The three 24x24 coordinate squares set the stage split; the limit
//   squares are kept in registers refreshed from the range registers.
// - Reset (synchronous, active low) empties the pipeline, restores the
//   register defaults and clears the decimation count and frame base time.
// - A stalled receiver holds the output register; the stages behind it fill
//   and o_ready drops only once every stage holds a point.
module lidar_point_qualifier
    import lpq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input point channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_frame_start,
    input  logic signed [COORD_W-1:0]  i_coord_x,
    input  logic signed [COORD_W-1:0]  i_coord_y,
    input  logic signed [COORD_W-1:0]  i_coord_z,
    input  logic [7:0]                 i_reflect,
    input  logic [7:0]                 i_tag_bits,
    input  logic [7:0]                 i_scan_line,
    input  logic [TIME_W-1:0]          i_point_time_ns,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [COORD_W-1:0]  o_out_x,
    output logic signed [COORD_W-1:0]  o_out_y,
    output logic signed [COORD_W-1:0]  o_out_z,
    output logic [7:0]                 o_out_intensity,
    output logic [OFFSET_W-1:0]        o_time_offset_ns,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]         r_decimation;
    logic [RANGE_W-1:0] r_min_range;
    logic [RANGE_W-1:0] r_max_range;
    logic               r_time_mode;
    logic [LIM_W-1:0]   r_lo2;
    logic [LIM_W-1:0]   r_hi2;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimation <= DECIMATION_RST;
            r_min_range  <= MIN_RANGE_RST;
            r_max_range  <= MAX_RANGE_RST;
            r_time_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DECIMATION: r_decimation <= pwdata[7:0];
                REG_MIN_RANGE:  r_min_range  <= pwdata[RANGE_W-1:0];
                REG_MAX_RANGE:  r_max_range  <= pwdata[RANGE_W-1:0];
                REG_TIME_MODE:  r_time_mode  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DECIMATION: prdata = {24'd0, r_decimation};
            REG_MIN_RANGE:  prdata = {{(32-RANGE_W){1'b0}}, r_min_range};
            REG_MAX_RANGE:  prdata = {{(32-RANGE_W){1'b0}}, r_max_range};
            REG_TIME_MODE:  prdata = {31'd0, r_time_mode};
            default:        prdata = '0;
        endcase
    end

    // Squared limits, refreshed every cycle. User keeps config quiet while points fly; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo2 <= '0;
            r_hi2 <= '1;
        end else begin
            r_lo2 <= r_min_range * r_min_range;
            r_hi2 <= r_max_range * r_max_range;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage advances when the next has room
    // ------------------------------------------------------------------
    logic r_a_v;
    logic r_b_v;
    logic r_o_v;
    logic out_free;
    logic b_free;
    logic a_free;
    logic in_xact;

    assign out_free = !r_o_v || i_ready;
    assign b_free   = !r_b_v || out_free;
    assign a_free   = !r_a_v || b_free;
    assign o_ready  = a_free;
    assign in_xact  = i_valid && a_free;
    assign o_valid  = r_o_v;

    // ------------------------------------------------------------------
    // Decimation and frame base time, updated per input transaction
    // ------------------------------------------------------------------
    t_decim_info decim_info;

    lpq_decim u_decim (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_xact),
        .i_frame_start (i_frame_start),
        .i_time_ns     (i_point_time_ns),
        .i_decimation  (r_decimation),
        .o_info        (decim_info)
    );

    // The decimation keep flag and cheap checks on the line number and confidence go in with the point.
    logic pre_ok;
    logic [7:0] conf;

    always_comb begin
        conf   = i_tag_bits & CONF_MASK;
        pre_ok = decim_info.keep && (i_scan_line < LINE_LIMIT)
                 && (conf == CONF_MID || conf == CONF_HIGH);
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_a_x, r_a_y, r_a_z;
    logic [7:0]                r_a_int;
    logic                      r_a_ok;
    logic [TIME_W-1:0]         r_a_t;
    logic [TIME_W-1:0]         r_a_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_free) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_a_x    <= i_coord_x;
            r_a_y    <= i_coord_y;
            r_a_z    <= i_coord_z;
            r_a_int  <= i_reflect;
            r_a_ok   <= pre_ok;
            r_a_t    <= i_point_time_ns;
            r_a_base <= decim_info.base_ns;
        end
    end

    // Magnitudes feed unsigned squares; -2^23 maps to 2^23, fits 24 bits.
    logic [COORD_W-1:0] mag_x, mag_y, mag_z;
    logic [TIME_W:0]    rel_diff;
    logic [TIME_W-1:0]  rel_ns;
    logic [OFFSET_W-1:0] off_sat;

    always_comb begin
        mag_x = r_a_x[COORD_W-1] ? (~r_a_x + 1'b1) : r_a_x;
        mag_y = r_a_y[COORD_W-1] ? (~r_a_y + 1'b1) : r_a_y;
        mag_z = r_a_z[COORD_W-1] ? (~r_a_z + 1'b1) : r_a_z;

        // Relative time clamps at zero when the stamp precedes the frame base.
        rel_diff = {1'b0, r_a_t} - {1'b0, r_a_base};
        if (r_time_mode) begin
            rel_ns = rel_diff[TIME_W] ? '0 : rel_diff[TIME_W-1:0];
        end else begin
            rel_ns = r_a_t;
        end
        off_sat = (|rel_ns[TIME_W-1:OFFSET_W]) ? '1 : rel_ns[OFFSET_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage B: squares and time offset
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_b_x, r_b_y, r_b_z;
    logic [7:0]                r_b_int;
    logic                      r_b_ok;
    logic [SQ_W-1:0]           r_b_sqx, r_b_sqy, r_b_sqz;
    logic [OFFSET_W-1:0]       r_b_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_free) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_v) begin
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            r_b_z   <= r_a_z;
            r_b_int <= r_a_int;
            r_b_ok  <= r_a_ok;
            r_b_sqx <= mag_x * mag_x;
            r_b_sqy <= mag_y * mag_y;
            r_b_sqz <= mag_z * mag_z;
            r_b_off <= off_sat;
        end
    end

    // Range gate: both limits inclusive; min above max passes nothing.
    logic [SUM_W-1:0] range_sq;
    logic             pass;

    always_comb begin
        range_sq = {2'b00, r_b_sqx} + {2'b00, r_b_sqy} + {2'b00, r_b_sqz};
        pass     = r_b_ok
                   && (range_sq >= {{(SUM_W-LIM_W){1'b0}}, r_lo2})
                   && (range_sq <= {{(SUM_W-LIM_W){1'b0}}, r_hi2});
    end

    // ------------------------------------------------------------------
    // Output register; rejected points are dropped here
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_free) begin
            r_o_v <= r_b_v && pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_b_v && pass) begin
            o_out_x          <= r_b_x;
            o_out_y          <= r_b_y;
            o_out_z          <= r_b_z;
            o_out_intensity  <= r_b_int;
            o_time_offset_ns <= r_b_off;
        end
    end

endmodule

>>> hdl/lpq_decim.sv
// Frame decimation counter and frame base timestamp.
`timescale 1ns / 1ps

module lpq_decim
    import lpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_frame_start,
    input  logic [TIME_W-1:0] i_time_ns,
    input  logic [7:0]        i_decimation,
    output t_decim_info       o_info
);

    logic [7:0]        r_skip_count;
    logic [7:0]        n_skip_count;
    logic [TIME_W-1:0] r_base_ns;
    logic [TIME_W-1:0] n_base_ns;
    logic [7:0]        cur_count;
    logic [7:0]        period;
    logic [8:0]        count_inc;

    always_comb begin
        period      = (i_decimation == 8'd0) ? 8'd1 : i_decimation;
        cur_count   = i_frame_start ? 8'd0 : r_skip_count;
        count_inc   = {1'b0, cur_count} + 9'd1;
        n_skip_count = (count_inc >= {1'b0, period}) ? 8'd0 : count_inc[7:0];
        n_base_ns   = i_frame_start ? i_time_ns : r_base_ns;
        o_info.keep    = (cur_count == 8'd0);
        o_info.base_ns = n_base_ns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count <= '0;
            r_base_ns    <= '0;
        end else if (i_step) begin
            r_skip_count <= n_skip_count;
            r_base_ns    <= n_base_ns;
        end
    end

endmodule

>>> sim/tb_lidar_point_qualifier.sv
// Testbench for lidar_point_qualifier: scoreboard, APB setup, directed and random points.
`timescale 1ns / 1ps

// One input transaction as the driver holds it.
typedef struct packed {
    logic                                frame_start;
    logic signed [lpq_pkg::COORD_W-1:0]  x;
    logic signed [lpq_pkg::COORD_W-1:0]  y;
    logic signed [lpq_pkg::COORD_W-1:0]  z;
    logic [7:0]                          reflect;
    logic [7:0]                          tag;
    logic [7:0]                          scan_line;
    logic [lpq_pkg::TIME_W-1:0]          stamp_ns;
} t_lidar_point;

// One output transaction: a point that survived decimation and the gates.
typedef struct packed {
    logic signed [lpq_pkg::COORD_W-1:0]  x;
    logic signed [lpq_pkg::COORD_W-1:0]  y;
    logic signed [lpq_pkg::COORD_W-1:0]  z;
    logic [7:0]                          intensity;
    logic [lpq_pkg::OFFSET_W-1:0]        offset_ns;
} t_kept_point;

// Tracks decimation and frame base time, predicts which points pass and
// holds them in order until the block delivers them.
class point_gate_checker;
    logic [7:0]                  decim;
    logic [lpq_pkg::RANGE_W-1:0] min_mm;
    logic [lpq_pkg::RANGE_W-1:0] max_mm;
    logic                        rel_time;
    logic [7:0]                  skip_cnt;
    logic [lpq_pkg::TIME_W-1:0]  base_ns;
    t_kept_point                 due_points[$];
    int                          n_points;
    int                          n_kept;
    int                          n_writes;
    int                          n_errors;

    function void reset();
        decim    = lpq_pkg::DECIMATION_RST;
        min_mm   = lpq_pkg::MIN_RANGE_RST;
        max_mm   = lpq_pkg::MAX_RANGE_RST;
        rel_time = 1'b0;
        skip_cnt = '0;
        base_ns  = '0;
        due_points.delete();
        n_points = 0;
        n_kept   = 0;
        n_writes = 0;
        n_errors = 0;
    endfunction

    function void write_reg(lpq_pkg::t_reg_idx idx, logic [31:0] val);
        case (idx)
            lpq_pkg::REG_DECIMATION: decim    = val[7:0];
            lpq_pkg::REG_MIN_RANGE:  min_mm   = val[lpq_pkg::RANGE_W-1:0];
            lpq_pkg::REG_MAX_RANGE:  max_mm   = val[lpq_pkg::RANGE_W-1:0];
            lpq_pkg::REG_TIME_MODE:  rel_time = val[0];
            default: ;
        endcase
        n_writes++;
    endfunction

    // |v| of a 24-bit value; the most negative value maps to 2^23.
    function logic [24:0] magnitude(logic signed [23:0] v);
        return v[23] ? (25'h100_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    function void note_point(t_lidar_point p);
        logic [8:0]                 period;
        logic [8:0]                 next_cnt;
        logic                       keep;
        logic [63:0]                ax, ay, az, r2, lo2, hi2;
        logic [lpq_pkg::TIME_W-1:0] span;
        t_kept_point                r;
        period = (decim == 8'd0) ? 9'd1 : {1'b0, decim};
        n_points++;
        if (p.frame_start) begin
            skip_cnt = '0;
            base_ns  = p.stamp_ns;
        end
        keep     = (skip_cnt == 8'd0);
        next_cnt = {1'b0, skip_cnt} + 9'd1;
        skip_cnt = (next_cnt >= period) ? 8'd0 : next_cnt[7:0];
        if (!keep || p.scan_line >= lpq_pkg::LINE_LIMIT)
            return;
        if ((p.tag & lpq_pkg::CONF_MASK) != lpq_pkg::CONF_MID &&
            (p.tag & lpq_pkg::CONF_MASK) != lpq_pkg::CONF_HIGH)
            return;
        ax  = 64'(magnitude(p.x));
        ay  = 64'(magnitude(p.y));
        az  = 64'(magnitude(p.z));
        r2  = ax * ax + ay * ay + az * az;
        lo2 = 64'(min_mm);
        lo2 = lo2 * lo2;
        hi2 = 64'(max_mm);
        hi2 = hi2 * hi2;
        if (r2 < lo2 || r2 > hi2)
            return;
        if (rel_time)
            span = (p.stamp_ns >= base_ns) ? p.stamp_ns - base_ns : '0;
        else
            span = p.stamp_ns;
        r.x         = p.x;
        r.y         = p.y;
        r.z         = p.z;
        r.intensity = p.reflect;
        r.offset_ns = (span > 63'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
        due_points.insert(due_points.size(), r);
    endfunction

    function void check_result(t_kept_point got);
        t_kept_point want;
        if (due_points.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: unexpected result x=%0d y=%0d z=%0d int=%0d off=%0d",
                         got.x, got.y, got.z, got.intensity, got.offset_ns);
            return;
        end
        want = due_points.pop_front();
        n_kept++;
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.intensity !== want.intensity || got.offset_ns !== want.offset_ns) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("ERROR: result %0d expected x=%0d y=%0d z=%0d int=%0d off=%0d",
                         n_kept, want.x, want.y, want.z, want.intensity, want.offset_ns);
                $display("       got                x=%0d y=%0d z=%0d int=%0d off=%0d",
                         got.x, got.y, got.z, got.intensity, got.offset_ns);
            end
        end
    endfunction

    function int outstanding();
        return due_points.size();
    endfunction

    // Anything still queued at the end never came out of the block.
    function void close_out();
        if (due_points.size() != 0) begin
            n_errors += due_points.size();
            $display("ERROR: %0d expected results never arrived", due_points.size());
        end
    endfunction
endclass

module tb_lidar_point_qualifier;
    import lpq_pkg::*;

    // Pipeline is three stages deep; leave a margin before touching registers.
    localparam int PIPE_SLACK  = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 120;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         i_ready = 1'b0;
    logic         psel    = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite  = 1'b0;
    logic [3:0]   paddr   = '0;
    logic [31:0]  pwdata  = '0;
    t_lidar_point drv_pt  = '0;

    logic                       o_ready;
    logic                       o_valid;
    logic signed [COORD_W-1:0]  o_out_x;
    logic signed [COORD_W-1:0]  o_out_y;
    logic signed [COORD_W-1:0]  o_out_z;
    logic [7:0]                 o_out_intensity;
    logic [OFFSET_W-1:0]        o_time_offset_ns;
    logic [31:0]                prdata;
    logic                       pready;

    // Idling knobs, percent of cycles the sender idles / the receiver stalls.
    int          send_idle_pct = 0;
    int          rcv_stall_pct = 0;
    // Timestamp of the current frame's first point, for random stimulus.
    logic [TIME_W-1:0] frame_ts = '0;

    point_gate_checker gate;

    lidar_point_qualifier DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_frame_start    (drv_pt.frame_start),
        .i_coord_x        (drv_pt.x),
        .i_coord_y        (drv_pt.y),
        .i_coord_z        (drv_pt.z),
        .i_reflect        (drv_pt.reflect),
        .i_tag_bits       (drv_pt.tag),
        .i_scan_line      (drv_pt.scan_line),
        .i_point_time_ns  (drv_pt.stamp_ns),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_z          (o_out_z),
        .o_out_intensity  (o_out_intensity),
        .o_time_offset_ns (o_time_offset_ns),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver backpressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // Monitor: values read here are the ones present before the edge.
    // Results are checked before the new point is noted; a point can never
    // produce its result at its own acceptance edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                gate.check_result('{o_out_x, o_out_y, o_out_z, o_out_intensity,
                                    o_time_offset_ns});
            if (i_valid && o_ready)
                gate.note_point(drv_pt);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Present one point, optionally after idle cycles, and hold it until taken.
    task automatic send_point(input t_lidar_point p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        drv_pt  <= p;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // APB write: setup phase, access phase, then back to idle before returning.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        gate.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] decim, input logic [31:0] lo_mm,
                             input logic [31:0] hi_mm, input logic [31:0] rel);
        apb_write(REG_DECIMATION, decim);
        apb_write(REG_MIN_RANGE, lo_mm);
        apb_write(REG_MAX_RANGE, hi_mm);
        apb_write(REG_TIME_MODE, rel);
    endtask

    // Stop sending and wait until every predicted point has come out, then
    // give dropped points still in the pipe time to leave.
    task automatic drain_results();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (gate.outstanding() > 0 && guard < 20000);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    function automatic t_lidar_point mk_point(input logic fs, input int x, input int y,
                                              input int z, input int refl, input int tag,
                                              input int line_no, input logic [63:0] t);
        t_lidar_point p;
        p.frame_start = fs;
        p.x           = x[23:0];
        p.y           = y[23:0];
        p.z           = z[23:0];
        p.reflect     = refl[7:0];
        p.tag         = tag[7:0];
        p.scan_line   = line_no[7:0];
        p.stamp_ns    = t[62:0];
        return p;
    endfunction

    // Random point: mostly plausible frames (good lines, good confidence,
    // timestamps near the frame start) with a share of junk mixed in.
    function automatic t_lidar_point rand_point();
        t_lidar_point       p;
        logic signed [23:0] c [3];
        int                 k;
        p.frame_start = ($urandom_range(0, 19) == 0);
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0: c[k] = 24'($urandom);
                1: begin
                    case ($urandom_range(0, 3))
                        0:       c[k] = 24'sh7F_FFFF;
                        1:       c[k] = 24'sh80_0000;
                        2:       c[k] = '0;
                        default: c[k] = '1;
                    endcase
                end
                // spread magnitudes evenly on a log scale
                default: begin
                    c[k] = 24'($urandom);
                    c[k] = c[k] >>> $urandom_range(0, 23);
                end
            endcase
        end
        p.x         = c[0];
        p.y         = c[1];
        p.z         = c[2];
        p.reflect   = 8'($urandom);
        p.tag       = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            p.tag[5] = 1'b0;
        p.scan_line = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
        if (p.frame_start) begin
            frame_ts   = $urandom_range(0, 1) ? 63'({$urandom, $urandom})
                                               : 63'($urandom_range(0, 1000000000));
            p.stamp_ns = frame_ts;
        end else begin
            case ($urandom_range(0, 9))
                0:       p.stamp_ns = 63'({$urandom, $urandom});
                1:       p.stamp_ns = frame_ts - $urandom_range(1, 5000);
                2:       p.stamp_ns = 63'(frame_ts + {$urandom_range(1, 15), $urandom});
                default: p.stamp_ns = frame_ts + $urandom_range(0, 2000000);
            endcase
        end
        return p;
    endfunction

    task automatic run_directed();
        // Reset settings: every point kept, full range, offset is the stamp.
        send_point(mk_point(0, 0, 0, 0, 0, 'h00, 0, 0));             // before any frame
        send_point(mk_point(1, 8388607, 0, 0, 255, 'h10, 3, 64'hFFFF_FFFF));
        send_point(mk_point(0, -8388607, 0, 0, 17, 'hCF, 0, 64'h1_0000_0000)); // on max
        send_point(mk_point(0, -8388608, 0, 0, 18, 'h00, 1, 5));     // just past max
        send_point(mk_point(0, 5, 5, 5, 1, 'h00, 4, 7));             // line too high
        send_point(mk_point(0, 5, 5, 5, 2, 'h00, 255, 7));
        send_point(mk_point(0, 5, 5, 5, 3, 'h20, 0, 7));             // low confidence
        send_point(mk_point(0, 5, 5, 5, 4, 'h30, 0, 7));
        send_point(mk_point(0, -1, -1, -1, 5, 'hDF, 2, 64'h7FFF_FFFF_FFFF_FFFF));
        send_point(mk_point(0, -8388608, -8388608, -8388608, 6, 'h00, 0, 9));
        drain_results();

        // Decimation zero acts as one; relative time with clamp and saturation.
        configure(0, 100, 1000, 1);
        send_point(mk_point(1, 100, 0, 0, 7, 'h00, 1, 1000));        // on min
        send_point(mk_point(0, 0, 1000, 0, 8, 'h10, 2, 500));        // stamp below base
        send_point(mk_point(0, 0, 0, -1001, 9, 'h00, 0, 2000));
        send_point(mk_point(0, 99, 0, 0, 10, 'h00, 0, 2000));
        send_point(mk_point(0, 0, 0, -999, 11, 'h00, 3, 64'h1_0000_03ED));
        send_point(mk_point(0, 0, -999, 0, 12, 'h00, 3, 64'h7FFF_FFFF_FFFF_FFFF));
        drain_results();

        // Minimum above maximum: nothing gets through.
        configure(3, 5000, 10, 0);
        send_point(mk_point(1, 7, 0, 0, 13, 'h00, 0, 1));
        send_point(mk_point(0, 5000, 0, 0, 14, 'h00, 0, 2));
        drain_results();

        // Keep one in three, restarted by each frame start.
        configure(3, 0, 8388607, 1);
        send_point(mk_point(1, 1, 2, 3, 20, 'h00, 0, 100));
        send_point(mk_point(0, 1, 2, 3, 21, 'h00, 0, 101));
        send_point(mk_point(0, 1, 2, 3, 22, 'h00, 0, 150));
        send_point(mk_point(0, 1, 2, 3, 23, 'h00, 0, 200));
        send_point(mk_point(1, 1, 2, 3, 24, 'h00, 0, 50));
        send_point(mk_point(0, 1, 2, 3, 25, 'h00, 0, 60));
        send_point(mk_point(1, 1, 2, 3, 26, 'h00, 0, 40));
        drain_results();
    endtask

    initial begin
        int ph;
        int i;
        int lo;
        int hi;
        int tmp;
        gate = new();
        gate.reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (ph = 0; ph < PHASES; ph++) begin
            // Idling pattern: none, sender mostly idle, receiver mostly
            // stalled, both lightly.
            case (ph % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 86; end
                default: begin send_idle_pct = 14; rcv_stall_pct = 14; end
            endcase
            case (ph)
                0: configure(1, 0, 8388607, 0);
                1: configure(255, 0, 8388607, 1);
                2: configure(2, 0, 3000000, 1);
                default: begin
                    lo = $urandom_range(0, 1500000);
                    hi = $urandom_range(lo, 8388607);
                    if ($urandom_range(0, 7) == 0) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    configure($urandom_range(0, 5), lo, hi, $urandom_range(0, 1));
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // halfway through, hold off until the block has emptied
                if (i == PHASE_ITEMS / 2)
                    drain_results();
                send_point(rand_point());
            end
            drain_results();
        end

        gate.close_out();
        $display("Streamed %0d points, %0d passed the gates and were checked, %0d register writes",
                 gate.n_points, gate.n_kept, gate.n_writes);
        $display("Covered decimation 0..255, both time modes, inverted range and four idling mixes");
        if (gate.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors", gate.n_errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> lidar_point_qualifier.f
hdl/lpq_pkg.sv
hdl/lpq_decim.sv
hdl/lidar_point_qualifier.sv
sim/tb_lidar_point_qualifier.sv
